// ----- src/fpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Flash page map package
// Geometry, codes and shared types of the page-mapped flash controller.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int BLK_PAGES       = 4;
  localparam int NUM_BLOCKS      = 8;
  localparam int MAX_LOGICAL     = 32;
  localparam int NUM_PAGES       = BLK_PAGES * NUM_BLOCKS;

  localparam int OFF_W  = 2;   // page offset inside a block
  localparam int BLK_W  = 3;   // physical block index
  localparam int PAGE_W = 5;   // physical page index
  localparam int LB_W   = 5;   // logical block index
  localparam int OWN_W  = 6;   // page owner code
  localparam int CFG_W  = 6;

  localparam logic [OWN_W-1:0] OwnStale = OWN_W'(MAX_LOGICAL + 1);
  localparam logic [CFG_W-1:0] CfgReset = CFG_W'(32);

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_COPY  = 3'd2,
    CMD_ERASE = 3'd3,
    CMD_NONE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BS_FREE    = 2'd0,
    BS_USED    = 2'd1,
    BS_GARBAGE = 2'd2,
    BS_COPY    = 2'd3
  } blk_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RANGE,
    S_MAP,
    S_FIND,
    S_GC,
    S_MOVE,
    S_ERASE,
    S_WRITE,
    S_FULL
  } state_e;

  typedef struct packed {
    logic              last;
    status_e           status;
    logic [BLK_W-1:0]  erase_block;
    logic [PAGE_W-1:0] source_page;
    logic [PAGE_W-1:0] target_page;
    cmd_e              command;
  } result_t;

endpackage

// ----- src/flash_page_map_with_gc_unit.sv -----
// ----------------------------------------------------------------------------
// Flash page map with garbage collection
// Page-mapped flash translation controller with one reserved copy block.
// ----------------------------------------------------------------------------
// Each input beat is a read or a write of one logical block; the unit answers
// with one or more command beats, the final one marked by tlast. A write runs
// a map lookup, a scan of up to 8 blocks, one block per cycle, for the lowest
// empty page outside the copy block, then the write beat. When no page is
// free, a collection pass runs: per garbage block one owner read per page plus
// the erase, then a second block scan. A stalled output holds up the item.
// Items are processed one at a time; the output register lets the next item
// in while the final beat waits to be taken. Page emptiness and map validity
// sit in flip-flops cleared by reset, so no clearing pass is needed.
// tdata out, from bit 0: command[2:0], target_page[7:3], source_page[12:8],
// erase_block[15:13], status[17:16], zero padding to 24 bits.
// ----------------------------------------------------------------------------
module flash_page_map_with_gc_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [fpm_pkg::CFG_W-1:0] cfg_wdata_i,  // logical_blocks
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // operation[0], logical_block[5:1]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [23:0]             m_axis_tdata,   // see head comment
  output logic                    m_axis_tlast    // last
);
  import fpm_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  cfg_q;
  logic              op_q;
  logic [LB_W-1:0]   lb_q;
  logic [BLK_W-1:0]  blk_q, g_q, c_q;
  logic [OFF_W-1:0]  j_q;
  logic [PAGE_W-1:0] page_q;
  logic              gc_done_q;

  blk_state_e        bstat_q [NUM_BLOCKS];
  logic [NUM_PAGES-1:0]   own_vld_q;   // clear = page empty
  logic [MAX_LOGICAL-1:0] map_vld_q;

  // output register
  logic    out_valid_q;
  result_t out_q;
  logic    out_free;
  logic    emit;
  result_t res;

  // memory ports
  logic              map_we, map_re, own_we, own_re;
  logic [LB_W-1:0]   map_waddr, map_raddr;
  logic [PAGE_W-1:0] map_wdata, map_rdata;
  logic [PAGE_W-1:0] own_waddr, own_raddr;
  logic [OWN_W-1:0]  own_wdata, own_rdata;

  // control pulses from the output block
  logic in_acc, oor, mark_stale, scan_adv, gc_start, gc_none, move_adv, erase_do;
  logic do_write;

  // search logic
  logic [BLK_PAGES-1:0] scan_empty, copy_empty;
  logic [OFF_W-1:0] scan_off, copy_off;
  logic             scan_hit;
  logic             gar_any;
  logic [BLK_W-1:0] gar_idx, copy_idx;
  logic [PAGE_W-1:0] cur_page;
  logic             cur_live;

  fpm_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_LOGICAL)) u_map_ram (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .re_i(map_re), .raddr_i(map_raddr), .rdata_o(map_rdata)
  );

  fpm_ram #(.WIDTH(OWN_W), .DEPTH(NUM_PAGES)) u_own_ram (
    .clk_i, .we_i(own_we), .waddr_i(own_waddr), .wdata_i(own_wdata),
    .re_i(own_re), .raddr_i(own_raddr), .rdata_o(own_rdata)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  // a register value of 32 or more lets every logical block through
  assign oor = ({1'b0, s_axis_tdata[5:1]} >= cfg_q);

  // lowest empty page of the scanned block and of the copy block
  always_comb begin
    scan_off = '0;
    copy_off = '0;
    for (int k = 0; k < BLK_PAGES; k++) begin
      scan_empty[k] = !own_vld_q[{blk_q, OFF_W'(k)}];
      copy_empty[k] = !own_vld_q[{c_q, OFF_W'(k)}];
    end
    for (int k = BLK_PAGES - 1; k >= 0; k--) begin
      if (scan_empty[k]) scan_off = OFF_W'(k);
      if (copy_empty[k]) copy_off = OFF_W'(k);
    end
    scan_hit = (bstat_q[blk_q] != BS_COPY) && (|scan_empty);
  end

  // lowest garbage block and the copy block
  always_comb begin
    gar_any  = 1'b0;
    gar_idx  = '0;
    copy_idx = '0;
    for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
      if (bstat_q[b] == BS_GARBAGE) begin
        gar_any = 1'b1;
        gar_idx = BLK_W'(b);
      end
      if (bstat_q[b] == BS_COPY) copy_idx = BLK_W'(b);
    end
  end

  assign cur_page = {g_q, j_q};
  assign cur_live = own_vld_q[cur_page] && !own_rdata[OWN_W-1];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = oor ? S_RANGE : S_MAP;
      S_RANGE: if (out_free) state_d = S_IDLE;
      S_MAP: begin
        if (op_q) state_d = S_FIND;
        else if (out_free) state_d = S_IDLE;
      end
      S_FIND: begin
        if (scan_hit) state_d = S_WRITE;
        else if (blk_q == BLK_W'(NUM_BLOCKS - 1)) state_d = gc_done_q ? S_FULL : S_GC;
      end
      S_GC:    state_d = gar_any ? S_MOVE : S_FIND;
      S_MOVE:  if (move_adv && j_q == OFF_W'(BLK_PAGES - 1)) state_d = S_ERASE;
      S_ERASE: if (out_free) state_d = S_GC;
      S_WRITE: if (out_free) state_d = S_IDLE;
      S_FULL:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs, memory accesses and control pulses
  always_comb begin
    emit       = 1'b0;
    res        = '{last: 1'b1, status: ST_OK, erase_block: '0, source_page: '0,
                   target_page: '0, command: CMD_NONE};
    map_re     = 1'b0;
    map_raddr  = s_axis_tdata[5:1];
    map_we     = 1'b0;
    map_waddr  = lb_q;
    map_wdata  = page_q;
    own_re     = 1'b0;
    own_raddr  = {gar_idx, OFF_W'(0)};
    own_we     = 1'b0;
    own_waddr  = page_q;
    own_wdata  = {1'b0, lb_q};
    mark_stale = 1'b0;
    scan_adv   = 1'b0;
    gc_start   = 1'b0;
    gc_none    = 1'b0;
    move_adv   = 1'b0;
    erase_do   = 1'b0;
    do_write   = 1'b0;
    case (state_q)
      S_IDLE: map_re = in_acc && !oor;
      S_RANGE: begin
        emit       = out_free;
        res.status = ST_RANGE;
      end
      S_MAP: begin
        if (!op_q) begin
          emit = out_free;
          if (map_vld_q[lb_q]) begin
            res.command     = CMD_READ;
            res.target_page = map_rdata;
          end else begin
            res.status = ST_UNMAPPED;
          end
        end else if (map_vld_q[lb_q]) begin
          // retire the old copy of this block
          mark_stale = 1'b1;
          own_we     = 1'b1;
          own_waddr  = map_rdata;
          own_wdata  = OwnStale;
        end
      end
      S_FIND: scan_adv = 1'b1;
      S_GC: begin
        gc_start = gar_any;
        gc_none  = !gar_any;
        own_re   = gar_any;
      end
      S_MOVE: begin
        move_adv = !cur_live || out_free;
        if (cur_live) begin
          emit            = out_free;
          res.command     = CMD_COPY;
          res.target_page = {c_q, copy_off};
          res.source_page = cur_page;
          res.last        = 1'b0;
          own_we          = out_free;
          own_waddr       = {c_q, copy_off};
          own_wdata       = own_rdata;
          map_we          = out_free;
          map_waddr       = own_rdata[LB_W-1:0];
          map_wdata       = {c_q, copy_off};
        end
        own_re    = move_adv && (j_q != OFF_W'(BLK_PAGES - 1));
        own_raddr = {g_q, j_q + OFF_W'(1)};
      end
      S_ERASE: begin
        emit            = out_free;
        erase_do        = out_free;
        res.command     = CMD_ERASE;
        res.erase_block = g_q;
        res.last        = 1'b0;
      end
      S_WRITE: begin
        emit            = out_free;
        do_write        = out_free;
        own_we          = out_free;
        map_we          = out_free;
        res.command     = CMD_WRITE;
        res.target_page = page_q;
      end
      S_FULL: begin
        emit       = out_free;
        res.status = ST_FULL;
      end
      default: ;
    endcase
  end

  // sequencer registers and the flip-flop tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CfgReset;
      out_valid_q <= 1'b0;
      own_vld_q   <= '0;
      map_vld_q   <= '0;
      blk_q       <= '0;
      gc_done_q   <= 1'b0;
      j_q         <= '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        bstat_q[b] <= (b == NUM_BLOCKS - 1) ? BS_COPY : BS_FREE;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (emit) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;

      if (mark_stale) begin
        map_vld_q[lb_q] <= 1'b0;
        bstat_q[map_rdata[PAGE_W-1:OFF_W]] <= BS_GARBAGE;
      end
      if (state_q == S_MAP) begin
        blk_q     <= '0;
        gc_done_q <= 1'b0;
      end
      if (scan_adv) begin
        blk_q <= blk_q + BLK_W'(1);
      end
      if (gc_none) begin
        gc_done_q <= 1'b1;
        blk_q     <= '0;
      end
      if (gc_start) j_q <= '0;
      if (move_adv) begin
        j_q <= j_q + OFF_W'(1);
        if (cur_live) begin
          own_vld_q[{c_q, copy_off}]        <= 1'b1;
          own_vld_q[cur_page]               <= 1'b0;
          map_vld_q[own_rdata[LB_W-1:0]]    <= 1'b1;
        end
      end
      if (erase_do) begin
        for (int k = 0; k < BLK_PAGES; k++) begin
          own_vld_q[{g_q, OFF_W'(k)}] <= 1'b0;
        end
        bstat_q[c_q] <= BS_USED;
        bstat_q[g_q] <= BS_COPY;
      end
      if (do_write) begin
        own_vld_q[page_q] <= 1'b1;
        map_vld_q[lb_q]   <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= s_axis_tdata[0];
      lb_q <= s_axis_tdata[5:1];
    end
    if (state_q == S_FIND && scan_hit) page_q <= {blk_q, scan_off};
    if (gc_start) begin
      g_q <= gar_idx;
      c_q <= copy_idx;
    end
    if (emit) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'b0, out_q.status, out_q.erase_block, out_q.source_page,
                          out_q.target_page, out_q.command};

`ifndef SYNTHESIS
  // exactly one copy block at all times
  a_one_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({bstat_q[7] == BS_COPY, bstat_q[6] == BS_COPY, bstat_q[5] == BS_COPY,
                bstat_q[4] == BS_COPY, bstat_q[3] == BS_COPY, bstat_q[2] == BS_COPY,
                bstat_q[1] == BS_COPY, bstat_q[0] == BS_COPY}) == 1)
    else $error("copy block count is not one");

  // copy and erase beats never close an item
  a_gc_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && (res.command == CMD_COPY || res.command == CMD_ERASE) |-> !res.last)
    else $error("collection beat marked last");

  // a new beat is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> !$past(emit))
    else $error("output beat overwritten");
`endif

endmodule

// ----- src/fpm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
